### src/esd_pkg.sv
// package for the escaped node stream deframer
// holds event codes, register map, config and result types; no dependencies
`default_nettype none

package esd_pkg;

    // deepest node allowed by default
    localparam int MAX_DEPTH_DEFAULT = 255;

    // configuration port geometry
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_START_MARKER  = 2'd0;
    localparam logic [1:0] REG_END_MARKER    = 2'd1;
    localparam logic [1:0] REG_ESCAPE_MARKER = 2'd2;

    // marker reset values
    localparam logic [7:0] START_MARKER_RST  = 8'd254;
    localparam logic [7:0] END_MARKER_RST    = 8'd255;
    localparam logic [7:0] ESCAPE_MARKER_RST = 8'd253;

    // result event codes
    localparam logic [2:0] EV_PAYLOAD   = 3'd0;
    localparam logic [2:0] EV_OPEN      = 3'd1;
    localparam logic [2:0] EV_CLOSE     = 3'd2;
    localparam logic [2:0] EV_DONE      = 3'd3;
    localparam logic [2:0] EV_SYNTAX    = 3'd4;
    localparam logic [2:0] EV_PREMATURE = 3'd5;
    localparam logic [2:0] EV_OVERFLOW  = 3'd6;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [7:0] escape_marker;
    } cfg_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] payload_byte;
        logic       type_byte;
        logic [7:0] nesting_depth;
    } res_t;

endpackage

`default_nettype wire

### src/esd_cfg_regs.sv
// marker registers behind the apb-style configuration port
// depends on esd_pkg
`default_nettype none

module esd_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [esd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [esd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [esd_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output esd_pkg::cfg_t                       cfg
);
    import esd_pkg::*;

    logic       wr_en;
    logic [1:0] reg_idx;
    logic [7:0] start_marker_reg;
    logic [7:0] end_marker_reg;
    logic [7:0] escape_marker_reg;
    logic [7:0] rd_byte;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg  <= START_MARKER_RST;
            end_marker_reg    <= END_MARKER_RST;
            escape_marker_reg <= ESCAPE_MARKER_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_START_MARKER:  start_marker_reg  <= pwdata[7:0];
                REG_END_MARKER:    end_marker_reg    <= pwdata[7:0];
                REG_ESCAPE_MARKER: escape_marker_reg <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_START_MARKER:  rd_byte = start_marker_reg;
            REG_END_MARKER:    rd_byte = end_marker_reg;
            REG_ESCAPE_MARKER: rd_byte = escape_marker_reg;
            default:           rd_byte = 8'd0;
        endcase
    end

    assign prdata = {{(APB_DATA_W-8){1'b0}}, rd_byte};

    assign cfg.start_marker  = start_marker_reg;
    assign cfg.end_marker    = end_marker_reg;
    assign cfg.escape_marker = escape_marker_reg;

endmodule

`default_nettype wire

### src/esd_parser.sv
// input register and parse state machine, one byte per cycle while results are taken
// depends on esd_pkg
`default_nettype none

module esd_parser #(
    parameter int MAX_DEPTH = esd_pkg::MAX_DEPTH_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  esd_pkg::cfg_t      cfg,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          in_kind,
    input  wire logic [7:0]    in_byte,
    input  wire logic          res_ready,
    output logic               res_load,
    output esd_pkg::res_t      res
);
    import esd_pkg::*;

    localparam int         LIMIT_INT   = (MAX_DEPTH > 255) ? 255 : MAX_DEPTH;
    localparam logic [7:0] DEPTH_LIMIT = 8'(LIMIT_INT);

    localparam logic [1:0] MODE_IDLE        = 2'd0;
    localparam logic [1:0] MODE_DATA        = 2'd1;
    localparam logic [1:0] MODE_AFTER_CLOSE = 2'd2;
    localparam logic [1:0] MODE_ERROR       = 2'd3;

    logic       in_vld_reg, in_vld_next;
    logic       in_kind_reg;
    logic [7:0] in_byte_reg;
    logic       accept;
    logic       advance;

    logic [1:0] mode_reg, mode_next;
    logic       esc_reg, esc_next;
    logic       first_reg, first_next;
    logic [7:0] depth_reg, depth_next;

    logic       is_start, is_end, is_esc;
    logic       do_open, do_close, do_payload, do_fail;
    logic [2:0] fail_ev;
    logic [7:0] open_base;
    logic       res_vld;
    logic [2:0] ev;
    logic [7:0] pb;
    logic       tb;

    // input register, refilled in the same cycle it drains
    assign in_ready = !in_vld_reg || res_ready;
    assign accept   = in_valid && in_ready;
    assign advance  = in_vld_reg && res_ready;

    always_comb
    begin
        if (accept)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_kind_reg <= in_kind;
            in_byte_reg <= in_byte;
        end
    end

    assign is_start  = (in_byte_reg == cfg.start_marker);
    assign is_end    = (in_byte_reg == cfg.end_marker);
    assign is_esc    = (in_byte_reg == cfg.escape_marker);
    assign open_base = (mode_reg == MODE_IDLE) ? 8'd0 : depth_reg;

    always_comb
    begin
        mode_next  = mode_reg;
        esc_next   = esc_reg;
        first_next = first_reg;
        depth_next = depth_reg;
        do_open    = 1'b0;
        do_close   = 1'b0;
        do_payload = 1'b0;
        do_fail    = 1'b0;
        fail_ev    = EV_SYNTAX;
        res_vld    = 1'b0;
        ev         = EV_PAYLOAD;
        pb         = 8'd0;
        tb         = 1'b0;

        case (mode_reg)
            MODE_IDLE:
            begin
                if (in_kind_reg)
                begin
                    depth_next = 8'd0;
                    ev         = EV_DONE;
                    res_vld    = 1'b1;
                end
                else if (is_start)
                    do_open = 1'b1;
                else
                    do_fail = 1'b1;
            end
            MODE_AFTER_CLOSE:
            begin
                if (in_kind_reg)
                begin
                    do_fail = 1'b1;
                    fail_ev = EV_PREMATURE;
                end
                else if (is_start)
                    do_open = 1'b1;
                else if (is_end)
                    do_close = 1'b1;
                else
                    do_fail = 1'b1;
            end
            MODE_DATA:
            begin
                if (in_kind_reg)
                begin
                    do_fail = 1'b1;
                    fail_ev = EV_PREMATURE;
                end
                else if (esc_reg)
                begin
                    esc_next   = 1'b0;
                    do_payload = 1'b1;
                end
                else if (is_start)
                    do_open = 1'b1;
                else if (is_end)
                    do_close = 1'b1;
                else if (is_esc)
                    esc_next = 1'b1;
                else
                    do_payload = 1'b1;
            end
            default:
            begin
                // error mode: silent until reset
            end
        endcase

        if (do_open)
        begin
            depth_next = open_base;
            if (open_base >= DEPTH_LIMIT)
            begin
                do_fail = 1'b1;
                fail_ev = EV_OVERFLOW;
            end
            else
            begin
                depth_next = open_base + 8'd1;
                mode_next  = MODE_DATA;
                first_next = 1'b1;
                ev         = EV_OPEN;
                res_vld    = 1'b1;
            end
        end

        if (do_close)
        begin
            depth_next = (depth_reg == 8'd0) ? 8'd0 : depth_reg - 8'd1;
            first_next = 1'b0;
            mode_next  = (depth_next == 8'd0) ? MODE_IDLE : MODE_AFTER_CLOSE;
            ev         = EV_CLOSE;
            res_vld    = 1'b1;
        end

        if (do_payload)
        begin
            tb         = first_reg;
            first_next = 1'b0;
            pb         = in_byte_reg;
            ev         = EV_PAYLOAD;
            res_vld    = 1'b1;
        end

        if (do_fail)
        begin
            mode_next  = MODE_ERROR;
            esc_next   = 1'b0;
            first_next = 1'b0;
            ev         = fail_ev;
            res_vld    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            esc_reg   <= 1'b0;
            first_reg <= 1'b0;
            depth_reg <= 8'd0;
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            esc_reg   <= esc_next;
            first_reg <= first_next;
            depth_reg <= depth_next;
        end
    end

    assign res_load          = advance && res_vld;
    assign res.event_res     = ev;
    assign res.payload_byte  = pb;
    assign res.type_byte     = tb;
    assign res.nesting_depth = depth_next;

    // error mode is sticky
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_ERROR) |=> (mode_reg == MODE_ERROR))
        else $error("left error mode without reset");

    // nothing comes out once in error mode
    a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_ERROR) |-> !res_vld)
        else $error("result produced in error mode");

    // depth never passes the limit
    a_depth_limit: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> (depth_reg <= DEPTH_LIMIT))
        else $error("nesting depth above limit");

    // waiting for a root means no open node
    a_idle_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_IDLE) |-> (depth_reg == 8'd0))
        else $error("idle with nonzero depth");

    // an escape can only be pending inside node data
    a_esc_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> (mode_reg == MODE_DATA))
        else $error("escape pending outside node data");

endmodule

`default_nettype wire

### src/esd_out_buf.sv
// result register toward the master-side stream
// depends on esd_pkg
`default_nettype none

module esd_out_buf (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     load,
    input  esd_pkg::res_t res,
    output logic          ready,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    output logic [15:0]   m_tdata,
    output logic [3:0]    m_tuser
);
    import esd_pkg::*;

    logic valid_reg, valid_next;
    res_t res_reg;

    assign ready = !valid_reg || m_tready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.nesting_depth, res_reg.payload_byte};
    assign m_tuser  = {res_reg.type_byte, res_reg.event_res};

endmodule

`default_nettype wire

### src/escaped_node_stream_deframer.sv
// top level of the escaped node stream deframer
// depends on esd_pkg, esd_cfg_regs, esd_parser, esd_out_buf
//
// usage:
//   slave side takes one transfer per raw byte: s_tdata is the byte,
//   s_tuser high marks end of stream (s_tdata then ignored)
//   master side gives at most one transfer per input byte: m_tuser holds the
//   event code and the type-byte flag, m_tdata the payload byte and depth
//   marker bytes are set over the apb port while the stream is quiet
// path: an input transfer reaches m_tvalid through the input register,
//   then the result register
// throughput: one byte per cycle; the parse state machine settles a byte
//   combinationally, so it takes a new transfer every clock while the
//   master side keeps up
// reset: parser waits for a root start marker, markers return to
//   254 / 255 / 253, both stream registers empty
// stall: when m_tready is low the result register holds; one more byte can
//   sit in the input register before s_tready drops
// after an error event the block stays silent until reset
`default_nettype none

module escaped_node_stream_deframer #(
    parameter int MAX_DEPTH = esd_pkg::MAX_DEPTH_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // slave-side stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // [7:0] stream_byte
    input  wire logic                           s_tuser,   // [0] kind
    // master-side stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [15:0]                         m_tdata,   // [7:0] payload_byte, [15:8] nesting_depth
    output logic [3:0]                          m_tuser,   // [2:0] event_res, [3] type_byte
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [esd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [esd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [esd_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);
    import esd_pkg::*;

    cfg_t cfg;
    res_t res;
    logic res_load;
    logic res_ready;

    // marker registers
    esd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register and parse logic
    esd_parser #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_byte   (s_tdata),
        .res_ready (res_ready),
        .res_load  (res_load),
        .res       (res)
    );

    // result register
    esd_out_buf u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_load),
        .res      (res),
        .ready    (res_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

### tb/escaped_node_stream_deframer_test.sv
// testbench for escaped_node_stream_deframer: directed table, then well-formed random node
// streams across several marker settings, ending on one sticky error; depends on esd_pkg and
// the deframer rtl only
module escaped_node_stream_deframer_test;
    import esd_pkg::*;

    localparam int DEPTH_PARAM = MAX_DEPTH_DEFAULT;
    // depth counter is 8 bits, so the usable limit never exceeds 255
    localparam int DEPTH_LIMIT = (DEPTH_PARAM > 255) ? 255 : DEPTH_PARAM;
    localparam int PHASE_ITEMS = 80;
    localparam int N_PHASES    = 5;
    localparam int HOLD_CYCLES = 64;
    localparam int DRAIN_WAIT  = 4;
    localparam int CYCLE_LIMIT = 200000;

    // parser view kept by the predictor
    typedef enum logic [1:0] {PM_IDLE, PM_DATA, PM_AFTER_CLOSE, PM_ERROR} parse_mode_e;
    // what one input byte does to the parser
    typedef enum {ACT_NONE, ACT_PAYLOAD, ACT_OPEN, ACT_CLOSE, ACT_DONE, ACT_FAIL} parse_act_e;
    // how a directed row is checked
    typedef enum {CHK_PRED, CHK_TYPED, CHK_SILENT} row_chk_e;
    // the one error the run closes on (errors hold until reset)
    typedef enum {FIN_NO_ROOT, FIN_DATA_AFTER_CLOSE, FIN_PREMATURE, FIN_OVERFLOW} closing_err_e;

    typedef struct {
        bit         eos;
        logic [7:0] sbyte;
        row_chk_e   chk;
        logic [2:0] ev;
        logic [7:0] pbyte;
        bit         tflag;
        logic [7:0] dep;
    } dir_row_t;

    // directed rows under reset markers: start fe, end ff, escape fd
    dir_row_t dir_tab [24] = '{
        '{1'b1, 8'h00, CHK_TYPED,  EV_DONE,    8'h00, 1'b0, 8'd0}, // end of stream while idle
        '{1'b1, 8'hFF, CHK_TYPED,  EV_DONE,    8'h00, 1'b0, 8'd0}, // byte ignored at end of stream
        '{1'b0, 8'hFE, CHK_TYPED,  EV_OPEN,    8'h00, 1'b0, 8'd1}, // root opens
        '{1'b0, 8'h00, CHK_TYPED,  EV_PAYLOAD, 8'h00, 1'b1, 8'd1}, // type byte, lowest value
        '{1'b0, 8'hFD, CHK_SILENT, EV_PAYLOAD, 8'h00, 1'b0, 8'd0}, // escape only arms
        '{1'b0, 8'hFF, CHK_TYPED,  EV_PAYLOAD, 8'hFF, 1'b0, 8'd1}, // escaped end marker
        '{1'b0, 8'hFD, CHK_SILENT, EV_PAYLOAD, 8'h00, 1'b0, 8'd0},
        '{1'b0, 8'hFE, CHK_PRED,   EV_PAYLOAD, 8'h00, 1'b0, 8'd0}, // escaped start marker
        '{1'b0, 8'hFD, CHK_SILENT, EV_PAYLOAD, 8'h00, 1'b0, 8'd0},
        '{1'b0, 8'hFD, CHK_PRED,   EV_PAYLOAD, 8'h00, 1'b0, 8'd0}, // escaped escape marker
        '{1'b0, 8'hFE, CHK_TYPED,  EV_OPEN,    8'h00, 1'b0, 8'd2},
        '{1'b0, 8'hFF, CHK_TYPED,  EV_CLOSE,   8'h00, 1'b0, 8'd1}, // child with no type byte
        '{1'b0, 8'hFE, CHK_TYPED,  EV_OPEN,    8'h00, 1'b0, 8'd2}, // open straight after close
        '{1'b0, 8'hFD, CHK_SILENT, EV_PAYLOAD, 8'h00, 1'b0, 8'd0},
        '{1'b0, 8'hFF, CHK_PRED,   EV_PAYLOAD, 8'h00, 1'b0, 8'd0}, // escaped type byte
        '{1'b0, 8'h7F, CHK_PRED,   EV_PAYLOAD, 8'h00, 1'b0, 8'd0},
        '{1'b0, 8'hFE, CHK_PRED,   EV_PAYLOAD, 8'h00, 1'b0, 8'd0},
        '{1'b0, 8'h80, CHK_PRED,   EV_PAYLOAD, 8'h00, 1'b0, 8'd0},
        '{1'b0, 8'hFF, CHK_PRED,   EV_PAYLOAD, 8'h00, 1'b0, 8'd0},
        '{1'b0, 8'hFF, CHK_PRED,   EV_PAYLOAD, 8'h00, 1'b0, 8'd0}, // close straight after close
        '{1'b0, 8'hFF, CHK_TYPED,  EV_CLOSE,   8'h00, 1'b0, 8'd0}, // root closes, back to idle
        '{1'b0, 8'hFE, CHK_PRED,   EV_PAYLOAD, 8'h00, 1'b0, 8'd0}, // new root
        '{1'b0, 8'hFF, CHK_PRED,   EV_PAYLOAD, 8'h00, 1'b0, 8'd0}, // empty root
        '{1'b1, 8'h5A, CHK_PRED,   EV_PAYLOAD, 8'h00, 1'b0, 8'd0}
    };

    // marker settings for the random phases: extremes, then the equal-marker
    // priority cases; the last phase draws its own distinct values
    cfg_t phase_markers [N_PHASES-1] = '{
        '{8'h00, 8'hFF, 8'h01},
        '{8'hFF, 8'h00, 8'h80},
        '{8'h10, 8'h20, 8'h20}, // end outranks escape
        '{8'h30, 8'h31, 8'h30}  // start outranks escape
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = 8'h00;  // [7:0] stream_byte
    logic s_tuser = 1'b0;         // [0] kind
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [15:0] m_tdata;         // [7:0] payload_byte, [15:8] nesting_depth
    logic [3:0] m_tuser;          // [2:0] event_res, [3] type_byte
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    // predictor state and its copy of the marker registers
    cfg_t        markers;
    parse_mode_e pmode;
    bit          esc_pend;
    bit          type_pend;
    logic [7:0]  depth;

    res_t due_events [$];   // events still owed by the block, oldest first
    res_t got;
    res_t want;
    int   n_bytes_in = 0;
    int   n_events_out = 0;
    int   mismatches = 0;
    int   cycles = 0;
    int   hold_reqs = 0;    // bumped by the sender to ask for a long receiver hold
    int   hold_seen = 0;
    int   stall_left = 0;
    bit   calm = 1'b0;      // both sides stop idling while set

    escaped_node_stream_deframer #(
        .MAX_DEPTH(DEPTH_PARAM)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // period 8
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // advance the parser by one input transfer; returns 1 when an event comes out
    function automatic bit deframe(input bit eos, input logic [7:0] b, output res_t r);
        parse_act_e act;
        logic [2:0] err_code;
        r = '0;
        act = ACT_NONE;
        err_code = EV_SYNTAX;
        if (pmode == PM_IDLE)
        begin
            // only a start marker or end of stream is legal before a root
            if (eos)
                act = ACT_DONE;
            else if (b == markers.start_marker)
            begin
                depth = '0;
                act = ACT_OPEN;
            end
            else
                act = ACT_FAIL;
        end
        else if (pmode != PM_ERROR)
        begin
            if (eos)
            begin
                act = ACT_FAIL;
                err_code = EV_PREMATURE;
            end
            else if (pmode == PM_AFTER_CLOSE)
            begin
                // after a close only another open or a close may follow
                if (b == markers.start_marker)
                    act = ACT_OPEN;
                else if (b == markers.end_marker)
                    act = ACT_CLOSE;
                else
                    act = ACT_FAIL;
            end
            else if (esc_pend)
            begin
                esc_pend = 1'b0;
                act = ACT_PAYLOAD;
            end
            // marker priority: start, then end, then escape
            else if (b == markers.start_marker)
                act = ACT_OPEN;
            else if (b == markers.end_marker)
                act = ACT_CLOSE;
            else if (b == markers.escape_marker)
                esc_pend = 1'b1;
            else
                act = ACT_PAYLOAD;
        end
        if (act == ACT_OPEN && depth >= DEPTH_LIMIT)
        begin
            act = ACT_FAIL;
            err_code = EV_OVERFLOW;
        end
        case (act)
            ACT_OPEN:
            begin
                depth = depth + 8'd1;
                pmode = PM_DATA;
                type_pend = 1'b1;
                r.event_res = EV_OPEN;
            end
            ACT_CLOSE:
            begin
                if (depth != 0)
                    depth = depth - 8'd1;
                type_pend = 1'b0;
                pmode = (depth == 0) ? PM_IDLE : PM_AFTER_CLOSE;
                r.event_res = EV_CLOSE;
            end
            ACT_PAYLOAD:
            begin
                r.event_res = EV_PAYLOAD;
                r.payload_byte = b;
                r.type_byte = type_pend;
                type_pend = 1'b0;
            end
            ACT_DONE:
            begin
                depth = '0;
                r.event_res = EV_DONE;
            end
            ACT_FAIL:
            begin
                // sticky until reset
                pmode = PM_ERROR;
                esc_pend = 1'b0;
                type_pend = 1'b0;
                r.event_res = err_code;
            end
            default: ;
        endcase
        r.nesting_depth = depth;
        return act != ACT_NONE;
    endfunction

    function automatic bit is_marker(input logic [7:0] b);
        return b == markers.start_marker || b == markers.end_marker
            || b == markers.escape_marker;
    endfunction

    // offer one byte transfer, wait for it to be taken, then log what it should cause
    task automatic feed(input bit eos, input logic [7:0] b, input row_chk_e chk = CHK_PRED,
                        input res_t typed = '0);
        res_t r;
        bit   has;
        if (!calm && $urandom_range(99) < 21)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= eos;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_bytes_in++;
        has = deframe(eos, b, r);
        if (chk == CHK_TYPED)
            due_events.push_back(typed);
        else if (chk == CHK_PRED && has)
            due_events.push_back(r);
    endtask

    // stop sending and wait until every owed event has come out
    task automatic drain_events();
        s_tvalid <= 1'b0;
        while (due_events.size() != 0)
            @(posedge clk);
        // a trailing escape marker causes no event; give it time to settle
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_START_MARKER:  markers.start_marker = v;
            REG_END_MARKER:    markers.end_marker = v;
            REG_ESCAPE_MARKER: markers.escape_marker = v;
            default: ;
        endcase
        // idle the bus before the next setup so it never lands on this edge
        @(posedge clk);
    endtask

    task automatic set_markers(input cfg_t c);
        write_reg(REG_START_MARKER, c.start_marker);
        write_reg(REG_END_MARKER, c.end_marker);
        write_reg(REG_ESCAPE_MARKER, c.escape_marker);
    endtask

    // one payload byte, escaped when it collides with a marker (and at random otherwise) if escaping works
    task automatic send_payload();
        logic [7:0] b;
        bit         esc_ok;
        esc_ok = markers.escape_marker != markers.start_marker
              && markers.escape_marker != markers.end_marker;
        b = 8'($urandom_range(255));
        if (esc_ok && $urandom_range(99) < 15)
        begin
            case ($urandom_range(2))
                0: b = markers.start_marker;
                1: b = markers.end_marker;
                default: b = markers.escape_marker;
            endcase
        end
        if (esc_ok && (is_marker(b) || $urandom_range(99) < 10))
        begin
            feed(1'b0, markers.escape_marker);
            feed(1'b0, b);
        end
        else
        begin
            while (is_marker(b))
                b = 8'($urandom_range(255));
            feed(1'b0, b);
        end
    endtask

    // one well-formed root: open, payload bytes, children, close
    task automatic send_root();
        int lvl;
        int cap;
        bit deep;
        bit in_data;
        deep = ($urandom_range(9) == 0);
        cap = deep ? $urandom_range(30, 12) : $urandom_range(5, 1);
        feed(1'b0, markers.start_marker);
        lvl = 1;
        in_data = 1'b1;
        // deep roots dive straight down first
        while (deep && lvl < cap)
        begin
            if ($urandom_range(1))
                send_payload();
            feed(1'b0, markers.start_marker);
            lvl++;
        end
        while (lvl > 0)
        begin
            if (in_data && $urandom_range(99) < 60)
                send_payload();
            else if (lvl < cap && $urandom_range(99) < 40)
            begin
                feed(1'b0, markers.start_marker);
                lvl++;
                in_data = 1'b1;
            end
            else
            begin
                feed(1'b0, markers.end_marker);
                lvl--;
                in_data = 1'b0;
            end
        end
    endtask

    task automatic check_field(input string what, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
        end
    endtask

    // receiver: random backpressure, long holds on request, none while calm
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (hold_seen != hold_reqs)
        begin
            hold_seen = hold_reqs;
            stall_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= calm || ($urandom_range(99) >= 21);
    end

    // every event transfer is matched against the oldest owed event
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            got.event_res = m_tuser[2:0];
            got.type_byte = m_tuser[3];
            got.payload_byte = m_tdata[7:0];
            got.nesting_depth = m_tdata[15:8];
            if (due_events.size() == 0)
            begin
                mismatches++;
                $display("%0t: event with none expected, expected nothing, got %0d",
                         $time, got.event_res);
            end
            else
            begin
                want = due_events.pop_front();
                n_events_out++;
                check_field("event_res", 8'(want.event_res), 8'(got.event_res));
                check_field("payload_byte", want.payload_byte, got.payload_byte);
                check_field("type_byte", 8'(want.type_byte), 8'(got.type_byte));
                check_field("nesting_depth", want.nesting_depth, got.nesting_depth);
            end
        end
    end

    // hard stop if the run hangs
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int           i;
        int           p;
        int           phase_start;
        cfg_t         c;
        logic [7:0]   b;
        logic [7:0]   v;
        closing_err_e fin;

        markers = '{START_MARKER_RST, END_MARKER_RST, ESCAPE_MARKER_RST};
        pmode = PM_IDLE;
        esc_pend = 1'b0;
        type_pend = 1'b0;
        depth = '0;

        // hold reset, then release it on a clock edge
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table under the reset markers
        for (i = 0; i < $size(dir_tab); i++)
            feed(dir_tab[i].eos, dir_tab[i].sbyte, dir_tab[i].chk,
                 res_t'({dir_tab[i].ev, dir_tab[i].pbyte, dir_tab[i].tflag, dir_tab[i].dep}));
        drain_events();

        // random phases, one marker setting each
        for (p = 0; p < N_PHASES; p++)
        begin
            if (p < N_PHASES - 1)
                c = phase_markers[p];
            else
            begin
                do
                begin
                    c.start_marker = 8'($urandom_range(255));
                    c.end_marker = 8'($urandom_range(255));
                    c.escape_marker = 8'($urandom_range(255));
                end
                while (c.start_marker == c.end_marker || c.end_marker == c.escape_marker
                       || c.start_marker == c.escape_marker);
            end
            set_markers(c);
            // one phase runs with no idling on either side
            if (p == 3)
                calm <= 1'b1;
            phase_start = n_bytes_in;
            while (n_bytes_in - phase_start < PHASE_ITEMS)
            begin
                // long receiver hold while the sender keeps offering
                if (p < 2 && hold_seen == hold_reqs && hold_reqs < p + 1
                    && n_bytes_in - phase_start > 20)
                    hold_reqs <= hold_reqs + 1;
                // sender pause until the block has emptied
                if (p == 2 && n_bytes_in - phase_start > 30 && n_bytes_in - phase_start < 40)
                    drain_events();
                send_root();
                if ($urandom_range(99) < 30)
                    feed(1'b1, 8'($urandom_range(255)));
            end
            drain_events();
            calm <= 1'b0;
        end

        // close on one error; the block must stay silent afterward
        fin = closing_err_e'($urandom_range(3));
        case (fin)
            FIN_NO_ROOT:
            begin
                b = 8'($urandom_range(255));
                while (b == markers.start_marker)
                    b = 8'($urandom_range(255));
                feed(1'b0, b);
            end
            FIN_DATA_AFTER_CLOSE:
            begin
                feed(1'b0, markers.start_marker);
                feed(1'b0, markers.start_marker);
                feed(1'b0, markers.end_marker);
                // the escape marker is just as illegal here as plain data
                if ($urandom_range(1))
                    b = markers.escape_marker;
                else
                begin
                    b = 8'($urandom_range(255));
                    while (b == markers.start_marker || b == markers.end_marker)
                        b = 8'($urandom_range(255));
                end
                feed(1'b0, b);
            end
            FIN_PREMATURE:
            begin
                feed(1'b0, markers.start_marker);
                send_payload();
                // sometimes the stream ends with an escape still pending
                if ($urandom_range(1))
                    feed(1'b0, markers.escape_marker);
                feed(1'b1, 8'($urandom_range(255)));
            end
            default:
            begin
                // all three markers equal: start wins, so every byte opens until the depth limit overflows
                v = 8'($urandom_range(255));
                set_markers('{v, v, v});
                repeat (DEPTH_LIMIT + 1) feed(1'b0, v);
            end
        endcase
        repeat (12) feed(1'($urandom_range(1)), 8'($urandom_range(255)));
        drain_events();
        repeat (8) @(posedge clk);

        $display("tb: %0d byte transfers in, %0d event transfers checked, %0d mismatches",
                 n_bytes_in, n_events_out, mismatches);
        $display("tb: reset markers plus %0d marker settings, closing error %s",
                 N_PHASES + (fin == FIN_OVERFLOW), fin.name());
        if (mismatches == 0 && due_events.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
